FILE: rtl/bps_pkg.sv
// Shared types, geometry constants and helpers for the branch predictor scorer.
`timescale 1ns / 1ps

package bps_pkg;

  // Store geometry: 2^ENTRIES_LOG2 tags split into 2^EFF_WAYS_LOG2 ways (WAYS_LOG2 capped at ENTRIES_LOG2)
  localparam int ENTRIES_LOG2  = 3;
  localparam int WAYS_LOG2     = 2;
  localparam int EFF_WAYS_LOG2 = (WAYS_LOG2 > ENTRIES_LOG2) ? ENTRIES_LOG2 : WAYS_LOG2;
  localparam int NUM_WAYS      = 1 << EFF_WAYS_LOG2;
  localparam int SET_BITS      = ENTRIES_LOG2 - EFF_WAYS_LOG2;
  localparam int NUM_SETS      = 1 << SET_BITS;
  localparam int SET_IDX_W     = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int TAG_W         = 30 - SET_BITS;

  localparam logic [31:0] START_PC_RESET = 32'h3000_0000;
  localparam logic [6:0]  OP_BRANCH      = 7'b1100011;
  localparam logic [6:0]  OP_JAL         = 7'b1101111;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_BRANCH = 2'd1;
  localparam logic [1:0] KIND_JAL    = 2'd2;

  typedef struct packed {
    logic [31:0] trace_pc;
    logic [31:0] trace_inst;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  scored_kind;
    logic        predicted_taken;
    logic        lookup_hit;
    logic        scored_correct;
    logic [31:0] branch_total;
    logic [31:0] branch_right;
    logic [31:0] jal_total;
    logic [31:0] jal_right;
  } out_word_t;

  // Classified work handed from the front end to the back end
  typedef struct packed {
    logic [1:0]  kind;
    logic        lookup;
    logic        fall_through;
    logic [31:0] pc;
  } job_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    sat_inc = (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

endpackage

FILE: rtl/bps_front.sv
// Front end: takes trace words, classifies the previous instruction, issues jobs.
`timescale 1ns / 1ps

module bps_front import bps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  in_word_t in_data,
  input  logic     jq_full,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic [31:0] cfg_data,
  output logic     jq_push,
  output job_t     jq_data
);

  logic [31:0] prev_pc_r, prev_pc_nxt;
  logic [31:0] prev_inst_r, prev_inst_nxt;
  logic        started_r, started_nxt;
  logic [6:0]  opcode;

  assign cfg_ready = 1'b1;
  assign jq_push   = in_push & ~jq_full;
  assign opcode    = prev_inst_r[6:0];

  always_comb begin
    jq_data.pc           = prev_pc_r;
    jq_data.fall_through = (in_data.trace_pc == prev_pc_r + 32'd4);
    case (opcode)
      OP_BRANCH: begin
        jq_data.kind   = KIND_BRANCH;
        // only backward branches go to the store
        jq_data.lookup = prev_inst_r[31];
      end
      OP_JAL: begin
        jq_data.kind   = KIND_JAL;
        jq_data.lookup = 1'b1;
      end
      default: begin
        jq_data.kind   = KIND_NONE;
        jq_data.lookup = 1'b0;
      end
    endcase
  end

  always_comb begin
    prev_pc_nxt   = prev_pc_r;
    prev_inst_nxt = prev_inst_r;
    started_nxt   = started_r;
    if (jq_push) begin
      prev_pc_nxt   = in_data.trace_pc;
      prev_inst_nxt = in_data.trace_inst;
      started_nxt   = 1'b1;
    end else if (cfg_valid && !started_r) begin
      // start pc only matters before the first word
      prev_pc_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pc_r   <= START_PC_RESET;
      prev_inst_r <= '0;
      started_r   <= 1'b0;
    end else begin
      prev_pc_r   <= prev_pc_nxt;
      prev_inst_r <= prev_inst_nxt;
      started_r   <= started_nxt;
    end
  end

endmodule

FILE: rtl/bps_job_q.sv
// Two-entry job queue between the front end and the back end.
`timescale 1ns / 1ps

module bps_job_q import bps_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

  job_t       data_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = data_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/bps_back.sv
// Back end: tag store lookup and FIFO insert, counters, and the result queue.
`timescale 1ns / 1ps

module bps_back import bps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      jq_empty,
  input  job_t      jq_data,
  output logic      jq_pop,
  input  logic      out_pop,
  output logic      out_empty,
  output out_word_t out_data
);

  logic [TAG_W-1:0] tags_r [NUM_SETS][NUM_WAYS];
  logic             vld_r  [NUM_SETS][NUM_WAYS];

  logic [31:0] br_tot_r, br_ok_r, jal_tot_r, jal_ok_r;
  logic [31:0] br_tot_nxt, br_ok_nxt, jal_tot_nxt, jal_ok_nxt;

  out_word_t  rq_r [2];
  logic       rq_wr_r, rq_rd_r;
  logic [1:0] rq_cnt_r, rq_cnt_nxt;

  logic                 fire, deliver;
  logic [SET_IDX_W-1:0] set_idx;
  logic [TAG_W-1:0]     tag;
  logic                 hit, insert;
  out_word_t            res;

  assign deliver = out_pop & ~out_empty;
  assign fire    = ~jq_empty & ((rq_cnt_r != 2'd2) | deliver);
  assign jq_pop  = fire;

  assign set_idx = (SET_BITS == 0) ? '0 : jq_data.pc[2 +: SET_IDX_W];
  assign tag     = jq_data.pc[31 -: TAG_W];

  always_comb begin
    hit = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (vld_r[set_idx][w] && tags_r[set_idx][w] == tag) hit = 1'b1;
    end
  end

  assign insert = fire & jq_data.lookup & ~hit;

  always_comb begin
    br_tot_nxt  = br_tot_r;
    br_ok_nxt   = br_ok_r;
    jal_tot_nxt = jal_tot_r;
    jal_ok_nxt  = jal_ok_r;

    res.scored_kind     = jq_data.kind;
    res.lookup_hit      = jq_data.lookup & hit;
    res.predicted_taken = 1'b0;
    res.scored_correct  = 1'b0;
    case (jq_data.kind)
      KIND_BRANCH: begin
        res.predicted_taken = jq_data.lookup & hit;
        // taken means the next pc is not the fall-through
        res.scored_correct  = res.predicted_taken ^ jq_data.fall_through;
        br_tot_nxt = sat_inc(br_tot_r);
        if (res.scored_correct) br_ok_nxt = sat_inc(br_ok_r);
      end
      KIND_JAL: begin
        res.predicted_taken = hit;
        res.scored_correct  = hit | jq_data.fall_through;
        jal_tot_nxt = sat_inc(jal_tot_r);
        if (res.scored_correct) jal_ok_nxt = sat_inc(jal_ok_r);
      end
      default: ;
    endcase

    res.branch_total = br_tot_nxt;
    res.branch_right = br_ok_nxt;
    res.jal_total    = jal_tot_nxt;
    res.jal_right    = jal_ok_nxt;
  end

  // on a miss, push the new tag in at way 0 and shift the set down
  always_ff @(posedge clk) begin
    if (insert) begin
      for (int w = NUM_WAYS - 1; w > 0; w--) begin
        tags_r[set_idx][w] <= tags_r[set_idx][w-1];
      end
      tags_r[set_idx][0] <= tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        for (int w = 0; w < NUM_WAYS; w++) begin
          vld_r[s][w] <= 1'b0;
        end
      end
    end else if (insert) begin
      for (int w = NUM_WAYS - 1; w > 0; w--) begin
        vld_r[set_idx][w] <= vld_r[set_idx][w-1];
      end
      vld_r[set_idx][0] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      br_tot_r  <= '0;
      br_ok_r   <= '0;
      jal_tot_r <= '0;
      jal_ok_r  <= '0;
    end else if (fire) begin
      br_tot_r  <= br_tot_nxt;
      br_ok_r   <= br_ok_nxt;
      jal_tot_r <= jal_tot_nxt;
      jal_ok_r  <= jal_ok_nxt;
    end
  end

  // result queue: hold finished words while the consumer stalls
  assign out_empty = (rq_cnt_r == 2'd0);
  assign out_data  = rq_r[rq_rd_r];

  always_comb begin
    rq_cnt_nxt = rq_cnt_r;
    if (fire && !deliver)      rq_cnt_nxt = rq_cnt_r + 2'd1;
    else if (deliver && !fire) rq_cnt_nxt = rq_cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rq_r[rq_wr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wr_r  <= 1'b0;
      rq_rd_r  <= 1'b0;
      rq_cnt_r <= 2'd0;
    end else begin
      if (fire)    rq_wr_r <= ~rq_wr_r;
      if (deliver) rq_rd_r <= ~rq_rd_r;
      rq_cnt_r <= rq_cnt_nxt;
    end
  end

endmodule

FILE: rtl/btb_branch_predictor_scorer.sv
// Top level of the branch target buffer prediction scorer.
//
//  channel  ports                          direction  word
//  in       in_push, in_full, in_data      consumer   in_word_t (trace pc, instruction)
//  out      out_pop, out_empty, out_data   producer   out_word_t (score, counters)
//  cfg      cfg_valid, cfg_ready, cfg_data consumer   start pc, 32 bits
//
// One word a cycle sustained while the job and result queues have room; a word's result
// reaches the output ports, where it can be popped, once the job queue has registered
// the word and the back end's set lookup and insert has loaded the result queue.
// The front end and back end stall independently through the two-entry job queue;
// the two-entry result queue keeps input flowing while a result waits.
// Synchronous active-low reset clears valid bits, counters and queues; cfg_ready is
// always high.
`timescale 1ns / 1ps

module btb_branch_predictor_scorer import bps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  in_word_t    in_data,
  output logic        in_full,
  output logic        out_empty,
  input  logic        out_pop,
  output out_word_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic jq_push, jq_pop, jq_full, jq_empty;
  job_t jq_in, jq_head;

  assign in_full = jq_full;

  bps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .jq_full   (jq_full),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .jq_push   (jq_push),
    .jq_data   (jq_in)
  );

  bps_job_q u_job_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (jq_push),
    .push_data (jq_in),
    .pop       (jq_pop),
    .head      (jq_head),
    .full      (jq_full),
    .empty     (jq_empty)
  );

  bps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .jq_empty  (jq_empty),
    .jq_data   (jq_head),
    .jq_pop    (jq_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_jal_hit_correct : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.scored_kind == KIND_JAL && out_data.lookup_hit)
      |-> out_data.scored_correct)
    else $error("jal hit not scored correct");

  a_none_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.scored_kind == KIND_NONE)
      |-> !(out_data.predicted_taken || out_data.lookup_hit || out_data.scored_correct))
    else $error("unscored word carries a prediction");

  a_taken_needs_hit : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.predicted_taken) |-> out_data.lookup_hit)
    else $error("taken prediction without a store hit");

  a_idle_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && jq_empty && out_empty) |-> ##2 !out_empty)
    else $error("result missing two cycles after an idle accept");
`endif

endmodule
